FILE: hw/rtl/msa_pkg.sv
package msa_pkg;

    localparam int STORE_BYTES_DEF  = 256;
    localparam int MSG_CAP_DEF      = 16;
    localparam int MAX_HOLES_DEF    = 8;
    localparam int ID_SLOTS_DEF     = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOUNTED  = 3'd0,
        CFG_MIN_ID   = 3'd1,
        CFG_MAX_ID   = 3'd2,
        CFG_MIN_SIZE = 3'd3,
        CFG_MAX_SIZE = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_UNMOUNTED  = 4'd1,
        ST_ID_HIGH    = 4'd2,
        ST_ID_LOW     = 4'd3,
        ST_OCCUPIED   = 4'd4,
        ST_EMPTY      = 4'd5,
        ST_TOO_LARGE  = 4'd6,
        ST_TOO_SMALL  = 4'd7,
        ST_TABLE_FULL = 4'd8,
        ST_NO_MEMORY  = 4'd9,
        ST_HOLES_FULL = 4'd10,
        ST_READ_LONG  = 4'd11
    } t_status;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] msg_id;
        logic [7:0] byte_count;
        logic [7:0] target;
        logic [7:0] lifetime;
    } t_req;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] location;
        logic [7:0] length;
        logic [4:0] slot;
        logic       reused_hole;
    } t_rsp;

    typedef struct packed {
        logic       mounted;
        logic [5:0] min_id;
        logic [5:0] max_id;
        logic [7:0] min_size;
        logic [7:0] max_size;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic lookup;    // latch id map slot
        logic scan_rst;  // clear hole scan index
        logic scan_step; // advance hole scan index
        logic commit;    // apply the update and form the result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

FILE: hw/rtl/msa_ctrl.sv
module msa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  msa_pkg::t_sts i_sts,
    output msa_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import msa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SCAN, S_COMMIT, S_DONE} t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup   = 1'b1;
                o_cmd.scan_rst = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_COMMIT);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    a_done_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_done) else $error("done missing after commit");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load while busy");
    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> !o_cmd.commit) else $error("double commit");
endmodule

FILE: hw/rtl/msa_datapath.sv
module msa_datapath #(
    parameter int STORE_BYTES  = msa_pkg::STORE_BYTES_DEF,
    parameter int MSG_CAP      = msa_pkg::MSG_CAP_DEF,
    parameter int MAX_HOLES    = msa_pkg::MAX_HOLES_DEF,
    parameter int ID_SLOTS     = msa_pkg::ID_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  msa_pkg::t_cfg i_cfg,
    input  msa_pkg::t_req i_req,
    input  msa_pkg::t_cmd i_cmd,
    output msa_pkg::t_sts o_sts,
    output msa_pkg::t_rsp o_rsp
);
    import msa_pkg::*;

    localparam int SLOTS = MSG_CAP + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int HW    = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int HCW   = $clog2(MAX_HOLES + 1);
    localparam int IW    = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] size;
        logic [7:0] loc;
        logic [7:0] ttl;
        logic [7:0] targ;
    } t_msg;

    typedef struct packed {
        logic       valid;
        logic [7:0] id;
        logic [7:0] size;
        logic [7:0] loc;
        logic [7:0] ttl;
        logic [7:0] targ;
        logic [7:0] old_slot;
    } t_hole;

    logic [7:0] r_id_map   [ID_SLOTS];
    logic [ID_SLOTS-1:0] r_map_vld;
    t_msg       r_msg      [SLOTS];
    t_hole      r_hole     [MAX_HOLES];
    logic [7:0] r_next_loc;
    logic [7:0] r_next_slot;
    logic [7:0] r_msg_count;
    logic [7:0] r_hole_count;
    logic [7:0] r_hole_bytes;

    t_req       r_req;
    logic [7:0] r_map_slot;
    t_msg       r_entry;
    logic [HCW-1:0] r_scan;
    logic       r_hit_fit;
    logic [HW-1:0] r_fit_idx;
    logic       r_hit_free;
    logic [HW-1:0] r_free_idx;
    t_rsp       r_rsp;
    t_rsp       n_rsp;

    // id check and occupancy
    logic       id_in_map;
    logic [IW-1:0] id_idx;
    logic       occ;
    logic [7:0] size;
    logic [8:0] bump_end;
    t_hole      scan_e;
    logic [HW-1:0] scan_idx;
    t_status    st;
    logic       reuse;
    logic [7:0] new_loc;
    logic [7:0] new_slot;
    logic [7:0] eff_len;
    logic [SW-1:0] msg_idx;
    logic [SW-1:0] map_idx;
    logic       map_we;

    assign id_in_map = ({1'b0, r_req.msg_id} < 9'(ID_SLOTS));
    assign id_idx    = r_req.msg_id[IW-1:0];
    assign occ       = (r_map_slot != 8'd0) && (r_map_slot <= 8'(MSG_CAP));
    assign size      = r_req.byte_count;
    assign scan_idx  = r_scan[HW-1:0];
    assign scan_e    = r_hole[scan_idx];
    assign o_sts.scan_done = (r_scan == HCW'(MAX_HOLES));
    assign bump_end  = {1'b0, r_next_loc} + {1'b0, size};
    assign reuse     = (r_hole_bytes >= size) && r_hit_fit;
    assign new_loc   = reuse ? r_hole[r_fit_idx].loc : r_next_loc;
    assign new_slot  = reuse ? r_hole[r_fit_idx].old_slot : r_next_slot;
    assign eff_len   = (size == 8'd0) ? r_entry.size : size;
    assign msg_idx   = new_slot[SW-1:0];
    assign map_idx   = r_map_slot[SW-1:0];
    assign map_we    = i_cmd.commit && (st == ST_OK) && (r_req.op == OP_CREATE);

    always_comb begin
        st = ST_OK;
        if (r_req.op == OP_CREATE) begin
            priority if (!i_cfg.mounted) st = ST_UNMOUNTED;
            else if (r_req.msg_id > {2'b0, i_cfg.max_id} || !id_in_map) st = ST_ID_HIGH;
            else if (r_req.msg_id < {2'b0, i_cfg.min_id}) st = ST_ID_LOW;
            else if (occ) st = ST_OCCUPIED;
            else if (size > i_cfg.max_size) st = ST_TOO_LARGE;
            else if (size < i_cfg.min_size) st = ST_TOO_SMALL;
            else if (r_msg_count >= 8'(MSG_CAP)) st = ST_TABLE_FULL;
            else if (!reuse && bump_end >= 9'(STORE_BYTES)) st = ST_NO_MEMORY;
            else if (new_slot > 8'(MSG_CAP)) st = ST_TABLE_FULL;
            else st = ST_OK;
        end else if (r_req.op == OP_DELETE) begin
            priority if (!i_cfg.mounted) st = ST_UNMOUNTED;
            else if (r_req.msg_id > {2'b0, i_cfg.max_id} || !id_in_map) st = ST_ID_HIGH;
            else if (r_req.msg_id < {2'b0, i_cfg.min_id}) st = ST_ID_LOW;
            else if (!occ) st = ST_EMPTY;
            else if (!r_hit_free) st = ST_HOLES_FULL;
            else st = ST_OK;
        end else begin
            priority if (r_req.msg_id > {2'b0, i_cfg.max_id} || !id_in_map) st = ST_ID_HIGH;
            else if (r_req.msg_id < {2'b0, i_cfg.min_id}) st = ST_ID_LOW;
            else if (!occ) st = ST_EMPTY;
            else if (size > r_entry.size) st = ST_READ_LONG;
            else st = ST_OK;
        end
    end

    // result fields stay zero unless the item succeeds
    always_comb begin
        n_rsp        = '0;
        n_rsp.status = st;
        if (st == ST_OK) begin
            unique case (t_op'(r_req.op))
                OP_CREATE: begin
                    n_rsp.location    = new_loc;
                    n_rsp.length      = size;
                    n_rsp.slot        = new_slot[4:0];
                    n_rsp.reused_hole = reuse;
                end
                OP_DELETE: begin
                    n_rsp.location = r_entry.loc;
                    n_rsp.length   = r_entry.size;
                    n_rsp.slot     = r_map_slot[4:0];
                end
                OP_READ: begin
                    n_rsp.location = r_entry.loc;
                    n_rsp.length   = eff_len;
                    n_rsp.slot     = r_map_slot[4:0];
                end
                default: ;
            endcase
        end
    end

    // request capture, lookup and hole scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.lookup) begin
            r_map_slot <= (id_in_map && r_map_vld[id_idx]) ? r_id_map[id_idx] : 8'd0;
        end
        if (i_cmd.scan_rst) begin
            r_scan     <= '0;
            r_hit_fit  <= 1'b0;
            r_hit_free <= 1'b0;
            r_fit_idx  <= '0;
            r_free_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + HCW'(1);
            if (!r_hit_fit && scan_e.valid && scan_e.size >= size) begin
                r_hit_fit <= 1'b1;
                r_fit_idx <= scan_idx;
            end
            if (!r_hit_free && !scan_e.valid) begin
                r_hit_free <= 1'b1;
                r_free_idx <= scan_idx;
            end
        end
        // entry fetch in the cycle after the map read (first scan step)
        if (i_cmd.scan_step && r_scan == '0) begin
            r_entry <= occ ? r_msg[map_idx] : '0;
        end
    end

    // id map contents; an entry counts only while its valid bit is set
    always_ff @(posedge i_clk) begin
        if (map_we) r_id_map[id_idx] <= new_slot;
    end

    // stores and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            for (int i = 0; i < SLOTS; i++) r_msg[i] <= '0;
            for (int i = 0; i < MAX_HOLES; i++) r_hole[i] <= '0;
            r_next_loc   <= 8'd1;
            r_next_slot  <= 8'd1;
            r_msg_count  <= '0;
            r_hole_count <= '0;
            r_hole_bytes <= '0;
            r_rsp        <= '0;
        end else if (i_cmd.commit) begin
            r_rsp <= n_rsp;
            if (st == ST_OK) begin
                unique case (t_op'(r_req.op))
                    OP_CREATE: begin
                        r_map_vld[id_idx] <= 1'b1;
                        r_msg[msg_idx]   <= '{id: r_req.msg_id, size: size, loc: new_loc,
                                              ttl: r_req.lifetime, targ: r_req.target};
                        if (reuse) begin
                            r_hole_bytes      <= r_hole_bytes - size;
                            r_hole_count      <= r_hole_count - 8'd1;
                            r_hole[r_fit_idx] <= '0;
                        end else begin
                            r_next_loc  <= bump_end[7:0];
                            r_next_slot <= r_next_slot + 8'd1;
                        end
                        r_msg_count          <= r_msg_count + 8'd1;
                    end
                    OP_DELETE: begin
                        r_map_vld[id_idx]    <= 1'b0;
                        r_hole_count         <= r_hole_count + 8'd1;
                        r_hole_bytes         <= r_hole_bytes + r_entry.size;
                        r_hole[r_free_idx]   <= '{valid: 1'b1, id: r_entry.id,
                                                  size: r_entry.size, loc: r_entry.loc,
                                                  ttl: r_entry.ttl, targ: r_entry.targ,
                                                  old_slot: r_map_slot};
                        r_msg[map_idx]       <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_rsp = r_rsp;

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> r_scan < HCW'(MAX_HOLES)) else $error("scan overrun");
    a_holes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hole_count <= 8'(MAX_HOLES)) else $error("hole count overrun");
    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp.status != ST_OK |-> r_rsp.slot == '0 && r_rsp.length == '0)
        else $error("fields set on error");
endmodule

FILE: hw/rtl/message_slot_allocator.sv
// Message slot allocator: id-to-slot map, message table and deleted-hole table.
// Command channel: raise start with busy low and i_req (op, msg_id,
// byte_count, target, lifetime) valid; the item is taken at that edge.
// Result: o_done strobes for one cycle with o_rsp (status, location, length,
// slot, reused_hole). Ops create, delete and read give one result; the unused
// opcode runs through the engine but raises no strobe and changes nothing.
// Sequence: the accepted item looks up the id map, then walks the hole table
// one entry a cycle to find the first fitting hole and the first free hole,
// then commits; the result and o_done are registered at commit. busy drops in
// the cycle after done, so a new item is taken only once the last is through.
// The receiver cannot stall: o_done is shown for one cycle only; o_rsp holds.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write mounted, min_id,
// max_id, min_size, max_size (indices 0..4) at once; write only while idle.
// Reset (i_rst_n low, synchronous) zeroes the message and hole tables and id
// map valid bits; free location and slot pointers go to 1, config to defaults.
module message_slot_allocator #(
    parameter int STORE_BYTES  = msa_pkg::STORE_BYTES_DEF,
    parameter int MSG_CAP      = msa_pkg::MSG_CAP_DEF,
    parameter int MAX_HOLES    = msa_pkg::MAX_HOLES_DEF,
    parameter int ID_SLOTS     = msa_pkg::ID_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  msa_pkg::t_req                  i_req,
    output logic                           o_done,
    output msa_pkg::t_rsp                  o_rsp,
    input  logic                           i_cfg_we,
    input  logic [msa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [msa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msa_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic done;
    logic r_none;

    // register file; unknown indices are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mounted: 1'b0, min_id: 6'd1, max_id: 6'd63,
                       min_size: 8'd1, max_size: 8'd64};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOUNTED:  r_cfg.mounted  <= i_cfg_data[0];
                CFG_MIN_ID:   r_cfg.min_id   <= i_cfg_data[5:0];
                CFG_MAX_ID:   r_cfg.max_id   <= i_cfg_data[5:0];
                CFG_MIN_SIZE: r_cfg.min_size <= i_cfg_data;
                CFG_MAX_SIZE: r_cfg.max_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // remember an unused opcode so its completion stays silent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_none <= 1'b0;
        else if (cmd.load) r_none <= (i_req.op == OP_NONE);
    end

    msa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (done)
    );

    // unused opcode: block commit so no state changes
    t_cmd dp_cmd;
    always_comb begin
        dp_cmd        = cmd;
        dp_cmd.commit = cmd.commit && !r_none;
    end

    msa_datapath #(
        .STORE_BYTES  (STORE_BYTES),
        .MSG_CAP      (MSG_CAP),
        .MAX_HOLES    (MAX_HOLES),
        .ID_SLOTS     (ID_SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

    assign o_done = done && !r_none;

    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while idle");
    a_no_none_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_none |-> !o_done) else $error("result for unused opcode");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
endmodule

FILE: tb/message_slot_allocator_tb.sv
`timescale 1ns / 100ps

module message_slot_allocator_tb;
    import msa_pkg::*;

    localparam int STORE_BYTES  = STORE_BYTES_DEF;
    localparam int MSG_CAP      = MSG_CAP_DEF;
    localparam int MAX_HOLES    = MAX_HOLES_DEF;
    localparam int ID_SLOTS     = ID_SLOTS_DEF;
    // leave margin for the unused opcode drain
    localparam int DRAIN_CYCLES = MAX_HOLES + 10;

    // Allocator shadow: tracks the same stores as the block and forms the expected
    // response for each accepted create, delete or read; checks results in order.
    class slot_tracker;
        t_cfg       cfg;
        logic [4:0] id_map [ID_SLOTS];
        logic [7:0] m_id [MSG_CAP+1];
        logic [7:0] m_size [MSG_CAP+1];
        logic [7:0] m_loc [MSG_CAP+1];
        logic       h_valid [MAX_HOLES];
        logic [7:0] h_size [MAX_HOLES];
        logic [7:0] h_loc [MAX_HOLES];
        logic [4:0] h_slot [MAX_HOLES];
        logic [7:0] free_loc;
        logic [4:0] free_slot;
        logic [4:0] msg_count;
        logic [7:0] hole_bytes;
        t_rsp       pending [$];
        int         errors;

        function void clear();
            cfg = '{mounted: 1'b0, min_id: 6'd1, max_id: 6'd63,
                    min_size: 8'd1, max_size: 8'd64};
            foreach (id_map[i]) id_map[i] = '0;
            foreach (m_id[i]) begin
                m_id[i] = '0; m_size[i] = '0; m_loc[i] = '0;
            end
            foreach (h_valid[i]) begin
                h_valid[i] = 1'b0; h_size[i] = '0; h_loc[i] = '0; h_slot[i] = '0;
            end
            free_loc = 8'd1; free_slot = 5'd1; msg_count = '0; hole_bytes = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [7:0] val);
            case (idx)
                CFG_MOUNTED:  cfg.mounted  = val[0];
                CFG_MIN_ID:   cfg.min_id   = val[5:0];
                CFG_MAX_ID:   cfg.max_id   = val[5:0];
                CFG_MIN_SIZE: cfg.min_size = val;
                CFG_MAX_SIZE: cfg.max_size = val;
                default: ;
            endcase
        endfunction

        function t_status id_status(logic [7:0] id);
            if (id > cfg.max_id || id >= ID_SLOTS) return ST_ID_HIGH;
            if (id < cfg.min_id) return ST_ID_LOW;
            return ST_OK;
        endfunction

        function bit taken(logic [7:0] id);
            return id_map[id] != 0 && id_map[id] <= MSG_CAP;
        endfunction

        function t_rsp create(t_req r);
            t_rsp o;
            bit   reuse;
            int   h;
            logic [7:0] loc;
            logic [4:0] slot;
            o = '0; reuse = 0; h = 0; loc = '0; slot = '0;
            if (!cfg.mounted) begin o.status = ST_UNMOUNTED; return o; end
            o.status = id_status(r.msg_id);
            if (o.status != ST_OK) return o;
            if (taken(r.msg_id)) o.status = ST_OCCUPIED;
            else if (r.byte_count > cfg.max_size) o.status = ST_TOO_LARGE;
            else if (r.byte_count < cfg.min_size) o.status = ST_TOO_SMALL;
            else if (msg_count >= MSG_CAP) o.status = ST_TABLE_FULL;
            if (o.status != ST_OK) return o;
            if (hole_bytes >= r.byte_count) begin
                for (int i = 0; i < MAX_HOLES; i++)
                    if (!reuse && h_valid[i] && h_size[i] >= r.byte_count) begin
                        reuse = 1; h = i; loc = h_loc[i]; slot = h_slot[i];
                    end
            end
            if (!reuse) begin
                if (int'(free_loc) + int'(r.byte_count) >= STORE_BYTES) begin
                    o.status = ST_NO_MEMORY; return o;
                end
                loc = free_loc; slot = free_slot;
            end
            if (slot > MSG_CAP) begin o.status = ST_TABLE_FULL; return o; end
            id_map[r.msg_id] = slot;
            m_id[slot] = r.msg_id; m_size[slot] = r.byte_count; m_loc[slot] = loc;
            if (reuse) begin
                hole_bytes = hole_bytes - r.byte_count;
                h_valid[h] = 0; h_size[h] = '0; h_loc[h] = '0; h_slot[h] = '0;
            end else begin
                free_loc  = free_loc + r.byte_count;
                free_slot = free_slot + 5'd1;
            end
            msg_count = msg_count + 5'd1;
            o.location = loc; o.length = r.byte_count; o.slot = slot;
            o.reused_hole = reuse;
            return o;
        endfunction

        function t_rsp remove(t_req r);
            t_rsp o;
            int   h;
            logic [4:0] slot;
            o = '0; h = -1;
            if (!cfg.mounted) begin o.status = ST_UNMOUNTED; return o; end
            o.status = id_status(r.msg_id);
            if (o.status != ST_OK) return o;
            if (!taken(r.msg_id)) begin o.status = ST_EMPTY; return o; end
            for (int i = MAX_HOLES - 1; i >= 0; i--)
                if (!h_valid[i]) h = i;
            if (h < 0) begin o.status = ST_HOLES_FULL; return o; end
            slot = id_map[r.msg_id];
            id_map[r.msg_id] = '0;
            hole_bytes = hole_bytes + m_size[slot];
            h_valid[h] = 1; h_size[h] = m_size[slot]; h_loc[h] = m_loc[slot];
            h_slot[h] = slot;
            o.location = m_loc[slot]; o.length = m_size[slot]; o.slot = slot;
            m_id[slot] = '0; m_size[slot] = '0; m_loc[slot] = '0;
            return o;
        endfunction

        function t_rsp lookup(t_req r);
            t_rsp o;
            logic [4:0] slot;
            o = '0;
            o.status = id_status(r.msg_id);
            if (o.status != ST_OK) return o;
            if (!taken(r.msg_id)) begin o.status = ST_EMPTY; return o; end
            slot = id_map[r.msg_id];
            if (r.byte_count > m_size[slot]) begin o.status = ST_READ_LONG; return o; end
            o.location = m_loc[slot];
            o.length   = (r.byte_count == 0) ? m_size[slot] : r.byte_count;
            o.slot     = slot;
            return o;
        endfunction

        function void note_item(t_req r);
            case (t_op'(r.op))
                OP_CREATE: pending.push_back(create(r));
                OP_DELETE: pending.push_back(remove(r));
                OP_READ:   pending.push_back(lookup(r));
                default: ;
            endcase
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status != exp.status || got.location != exp.location ||
                got.length != exp.length || got.slot != exp.slot ||
                got.reused_hole != exp.reused_hole) begin
                $display("%0t: mismatch exp st=%0d loc=%0d len=%0d slot=%0d reuse=%0b",
                         $time, exp.status, exp.location, exp.length, exp.slot,
                         exp.reused_hole);
                $display("%0t:          act st=%0d loc=%0d len=%0d slot=%0d reuse=%0b",
                         $time, got.status, got.location, got.length, got.slot,
                         got.reused_hole);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    slot_tracker tracker = new();

    always #2 i_clk = ~i_clk;

    message_slot_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Results cannot be held off: take every strobe at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_rsp);
    end

    // Issue one item: random gap first, then hold start until the block takes it.
    task automatic send_item(t_op op, logic [7:0] id, logic [7:0] cnt,
                             logic [7:0] targ, logic [7:0] ttl);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        repeat (gap) @(posedge i_clk);
        start <= 1'b1;
        i_req <= '{op: op, msg_id: id, byte_count: cnt, target: targ, lifetime: ttl};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // item taken at this edge: record it before the engine moves on
        tracker.note_item(i_req);
        start <= 1'b0;
        i_req <= '{op: op, msg_id: 8'($urandom), byte_count: 8'($urandom),
                   target: 8'($urandom), lifetime: 8'($urandom)};
        // the block is busy now, so this edge costs no throughput
        @(posedge i_clk);
    endtask

    // Drain every expected result, let any unused-opcode item finish, then go idle.
    task automatic settle();
        int n;
        n = 0;
        while (tracker.pending.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic mnt, logic [5:0] lo_id, logic [5:0] hi_id,
                              logic [7:0] lo_sz, logic [7:0] hi_sz);
        settle();
        write_reg(CFG_MOUNTED, {7'd0, mnt});
        write_reg(CFG_MIN_ID, {2'd0, lo_id});
        write_reg(CFG_MAX_ID, {2'd0, hi_id});
        write_reg(CFG_MIN_SIZE, lo_sz);
        write_reg(CFG_MAX_SIZE, hi_sz);
    endtask

    // Random item with the id drawn mostly near the valid range so creates,
    // deletes and reads keep hitting live entries.
    task automatic random_item(int focus);
        t_op        op;
        logic [7:0] id, cnt;
        int         r;
        r = $urandom_range(0, 99);
        op = (r < 40) ? OP_CREATE : (r < 70) ? OP_DELETE : (r < 97) ? OP_READ : OP_NONE;
        if ($urandom_range(0, 9) < 8) id = 8'($urandom_range(0, focus));
        else id = 8'($urandom);
        case ($urandom_range(0, 4))
            0: cnt = 8'($urandom);
            1: cnt = 8'($urandom_range(0, 4));
            default: cnt = 8'($urandom_range(1, 40));
        endcase
        send_item(op, id, cnt, 8'($urandom), 8'($urandom));
    endtask

    initial begin
        tracker.clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unmounted: create and delete refuse, read still looks up.
        send_item(OP_CREATE, 8'd5, 8'd10, 8'hFF, 8'hFF);
        send_item(OP_DELETE, 8'd5, 8'd0, 8'h00, 8'h00);
        send_item(OP_READ, 8'd5, 8'd0, 8'h00, 8'h00);
        set_config(1'b1, 6'd1, 6'd63, 8'd1, 8'd255);
        // Id range checks and the id beyond the map.
        send_item(OP_CREATE, 8'd0, 8'd10, 8'h00, 8'h00);
        send_item(OP_CREATE, 8'd64, 8'd10, 8'h00, 8'h00);
        send_item(OP_CREATE, 8'd255, 8'd10, 8'h00, 8'h00);
        send_item(OP_CREATE, 8'd63, 8'd0, 8'h00, 8'h00);
        send_item(OP_CREATE, 8'd63, 8'd200, 8'hAA, 8'h55);
        send_item(OP_CREATE, 8'd1, 8'd60, 8'h55, 8'hAA);
        send_item(OP_CREATE, 8'd1, 8'd5, 8'h00, 8'h00);  // id 1 still free after the refusal above: created
        send_item(OP_READ, 8'd63, 8'd0, 8'h00, 8'h00);
        send_item(OP_READ, 8'd63, 8'd201, 8'h00, 8'h00); // read too long
        send_item(OP_READ, 8'd63, 8'd200, 8'h00, 8'h00);
        // Delete, then refill the hole with a smaller message (leftover lost).
        send_item(OP_DELETE, 8'd63, 8'd0, 8'h00, 8'h00);
        send_item(OP_DELETE, 8'd63, 8'd0, 8'h00, 8'h00); // empty
        send_item(OP_CREATE, 8'd2, 8'd100, 8'h01, 8'h02);
        send_item(OP_CREATE, 8'd3, 8'd50, 8'h01, 8'h02);  // no memory
        send_item(OP_NONE, 8'd2, 8'd0, 8'h00, 8'h00);
        send_item(OP_READ, 8'd2, 8'd1, 8'h00, 8'h00);
        set_config(1'b1, 6'd10, 6'd20, 8'd4, 8'd8);
        send_item(OP_CREATE, 8'd9, 8'd5, 8'h00, 8'h00);
        send_item(OP_CREATE, 8'd21, 8'd5, 8'h00, 8'h00);
        send_item(OP_CREATE, 8'd10, 8'd3, 8'h00, 8'h00);
        send_item(OP_CREATE, 8'd10, 8'd9, 8'h00, 8'h00);

        // Random phases, each from a fresh reset-like fill of the tables is not
        // possible, so vary limits: wide, narrow, extremes, small sizes to
        // cycle through many creates and deletes before the count saturates.
        for (int ph = 0; ph < 11; ph++) begin
            case (ph % 4)
                0: set_config(1'b1, 6'd1, 6'd63, 8'd1, 8'd64);
                1: set_config(1'b1, 6'($urandom_range(1, 20)), 6'($urandom_range(20, 63)),
                              8'($urandom_range(1, 8)), 8'($urandom_range(8, 255)));
                2: set_config(1'($urandom_range(0, 1)), 6'd63, 6'd1, 8'd255, 8'd1);
                default: set_config(1'b1, 6'd0, 6'd63, 8'd0, 8'd255);
            endcase
            for (int k = 0; k < 150; k++) random_item((ph % 2) ? 70 : 24);
        end

        settle();
        if (tracker.errors == 0) $display("** message_slot_allocator: PASSED **");
        else $display("** message_slot_allocator: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** message_slot_allocator: FAILED **");
        $finish;
    end

endmodule
